// ===== src/bts_pkg.sv =====
// Shared constants and types of the bilinear texture sampler.
package bts_pkg;

  localparam int STORE_TEXELS = 65536;
  localparam int ADDR_W       = $clog2(STORE_TEXELS);
  localparam int MAX_DIM      = 256;
  localparam int DIM_W        = 9;
  localparam int TEXEL_W      = 32;
  localparam int QUAD         = 4;

  typedef enum logic [2:0] {
    REG_TEX_WIDTH      = 3'd0,
    REG_TEX_HEIGHT     = 3'd1,
    REG_SCALE_U        = 3'd2,
    REG_SCALE_V        = 3'd3,
    REG_OFFSET_U       = 3'd4,
    REG_OFFSET_V       = 3'd5,
    REG_CLAMP_MODE     = 3'd6,
    REG_CHANNEL_SELECT = 3'd7
  } cfg_reg_t;

  typedef enum logic [2:0] {
    CH_RED   = 3'd0,
    CH_GREEN = 3'd1,
    CH_BLUE  = 3'd2,
    CH_ALPHA = 3'd3,
    CH_MEAN  = 3'd4
  } channel_t;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_SAMPLE = 1'b1
  } op_t;

  // Reciprocals for exact division by 255 and by 765 of values below 2^26.
  localparam logic [26:0] RECIP_255 = 27'd67372037;
  localparam int          SHIFT_255 = 34;
  localparam logic [26:0] RECIP_765 = 27'd89829382;
  localparam int          SHIFT_765 = 36;

endpackage

// ===== src/bilinear_texture_sampler.sv =====
// Top level of the bilinear texture sampler: coordinate pipeline, texel store and filter.
//
//   channel   signals                          direction  size
//   request   req_valid/req_stall + 5 fields   in         1 item per cycle
//   result    rsp_valid/rsp_stall + value      out        1 per sample request
//   config    cfg_valid/cfg_ready/index/data   in         1 write per cycle
//
// Each request passes through registered stages A to J and the output register.
// A new request is accepted every cycle; the four replicated texel memories
// give the four quad reads in one cycle. A stalled result holds in the output
// register and the next result waits in a skid register; only a full skid
// register freezes the pipeline and stalls the request side, from a register.
// Reset clears the pipeline valids and configuration; the texel store is not cleared.
module bilinear_texture_sampler (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  output logic                           req_stall,
  input  logic                           operation,
  input  logic [15:0]                    texel_index,
  input  logic [31:0]                    texel_rgba,
  input  logic signed [31:0]             coord_u,
  input  logic signed [31:0]             coord_v,
  output logic                           rsp_valid,
  input  logic                           rsp_stall,
  output logic [15:0]                    sample_value,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [2:0]                     cfg_index,
  input  logic [31:0]                    cfg_data
);

  logic [bts_pkg::DIM_W-1:0] tex_width;
  logic [bts_pkg::DIM_W-1:0] tex_height;
  logic signed [31:0]        scale_u;
  logic signed [31:0]        scale_v;
  logic signed [31:0]        offset_u;
  logic signed [31:0]        offset_v;
  logic                      clamp_mode;
  logic [2:0]                channel_select;

  logic adv;
  logic skid_valid;

  assign cfg_ready = 1'b1;
  assign adv       = !skid_valid;
  assign req_stall = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      tex_width      <= bts_pkg::DIM_W'(1);
      tex_height     <= bts_pkg::DIM_W'(1);
      scale_u        <= 32'sd65536;
      scale_v        <= 32'sd65536;
      offset_u       <= '0;
      offset_v       <= '0;
      clamp_mode     <= 1'b0;
      channel_select <= bts_pkg::CH_RED;
    end else if (cfg_valid && cfg_ready) begin
      unique case (bts_pkg::cfg_reg_t'(cfg_index))
        bts_pkg::REG_TEX_WIDTH:      tex_width      <= cfg_data[bts_pkg::DIM_W-1:0];
        bts_pkg::REG_TEX_HEIGHT:     tex_height     <= cfg_data[bts_pkg::DIM_W-1:0];
        bts_pkg::REG_SCALE_U:        scale_u        <= cfg_data;
        bts_pkg::REG_SCALE_V:        scale_v        <= cfg_data;
        bts_pkg::REG_OFFSET_U:       offset_u       <= cfg_data;
        bts_pkg::REG_OFFSET_V:       offset_v       <= cfg_data;
        bts_pkg::REG_CLAMP_MODE:     clamp_mode     <= cfg_data[0];
        bts_pkg::REG_CHANNEL_SELECT: channel_select <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // Effective sizes and their last index.
  logic [bts_pkg::DIM_W-1:0] w_eff, h_eff;
  logic [7:0]                w_last, h_last, w_mul, h_mul;

  function automatic logic [bts_pkg::DIM_W-1:0] eff_dim(input logic [bts_pkg::DIM_W-1:0] d);
    logic [bts_pkg::DIM_W-1:0] r;
    if (d == '0) begin
      r = bts_pkg::DIM_W'(1);
    end else if (d > bts_pkg::DIM_W'(bts_pkg::MAX_DIM)) begin
      r = bts_pkg::DIM_W'(bts_pkg::MAX_DIM);
    end else begin
      r = d;
    end
    return r;
  endfunction

  assign w_eff  = eff_dim(tex_width);
  assign h_eff  = eff_dim(tex_height);
  assign w_last = 8'(w_eff - bts_pkg::DIM_W'(1));
  assign h_last = 8'(h_eff - bts_pkg::DIM_W'(1));
  assign w_mul  = (w_eff > bts_pkg::DIM_W'(1)) ? w_last : 8'd1;
  assign h_mul  = (h_eff > bts_pkg::DIM_W'(1)) ? h_last : 8'd1;

  // Stage A: request register.
  logic               a_valid, a_op;
  logic [15:0]        a_index;
  logic [31:0]        a_rgba;
  logic signed [31:0] a_u, a_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_op    <= operation;
      a_index <= texel_index;
      a_rgba  <= texel_rgba;
      a_u     <= coord_u;
      a_v     <= coord_v;
    end
  end

  // Stage B: coordinate times scale.
  logic               b_valid, b_op;
  logic [15:0]        b_index;
  logic [31:0]        b_rgba;
  logic signed [63:0] b_pu, b_pv;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (adv) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_op    <= a_op;
      b_index <= a_index;
      b_rgba  <= a_rgba;
      b_pu    <= a_u * scale_u;
      b_pv    <= a_v * scale_v;
    end
  end

  // Stage C: floor shift, offset, then wrap or clamp.
  function automatic logic [16:0] map_frac(input logic signed [63:0] p,
                                           input logic signed [31:0] off,
                                           input logic clamp);
    logic signed [63:0] s;
    logic [16:0]        f;
    s = (p >>> 16) + $signed({{32{off[31]}}, off});
    if (clamp) begin
      if (s < 64'sd0) begin
        f = '0;
      end else if (s > 64'sd65536) begin
        f = 17'd65536;
      end else begin
        f = s[16:0];
      end
    end else begin
      f = {1'b0, s[15:0]};
    end
    return f;
  endfunction

  logic        c_valid, c_op;
  logic [15:0] c_index;
  logic [31:0] c_rgba;
  logic [16:0] c_fu, c_fv;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (adv) begin
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_op    <= b_op;
      c_index <= b_index;
      c_rgba  <= b_rgba;
      c_fu    <= map_frac(b_pu, offset_u, clamp_mode);
      c_fv    <= map_frac(b_pv, offset_v, clamp_mode);
    end
  end

  // Stage D: texel position in Q8.16.
  logic        d_valid, d_op;
  logic [15:0] d_index;
  logic [31:0] d_rgba;
  logic [24:0] d_px, d_py;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else if (adv) begin
      d_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_op    <= c_op;
      d_index <= c_index;
      d_rgba  <= c_rgba;
      d_px    <= c_fu * w_mul;
      d_py    <= c_fv * h_mul;
    end
  end

  // Quad addresses with edge clamping, issued to the memories.
  logic [8:0]                 x0r, y0r, x0, y0, x1, y1;
  logic [bts_pkg::ADDR_W-1:0] raddr [bts_pkg::QUAD];
  logic [bts_pkg::TEXEL_W-1:0] rdata [bts_pkg::QUAD];
  logic                       ram_we;

  always_comb begin
    x0r = d_px[24:16];
    y0r = d_py[24:16];
    x0  = (x0r > {1'b0, w_last}) ? {1'b0, w_last} : x0r;
    y0  = (y0r > {1'b0, h_last}) ? {1'b0, h_last} : y0r;
    x1  = (x0 + 9'd1 < {1'b0, w_last}) ? x0 + 9'd1 : {1'b0, w_last};
    y1  = (y0 + 9'd1 < {1'b0, h_last}) ? y0 + 9'd1 : {1'b0, h_last};
    raddr[0] = bts_pkg::ADDR_W'({7'd0, y0} * {7'd0, w_eff} + {7'd0, x0});
    raddr[1] = bts_pkg::ADDR_W'({7'd0, y0} * {7'd0, w_eff} + {7'd0, x1});
    raddr[2] = bts_pkg::ADDR_W'({7'd0, y1} * {7'd0, w_eff} + {7'd0, x0});
    raddr[3] = bts_pkg::ADDR_W'({7'd0, y1} * {7'd0, w_eff} + {7'd0, x1});
  end

  assign ram_we = adv && d_valid && (d_op == bts_pkg::OP_WRITE);

  for (genvar i = 0; i < bts_pkg::QUAD; i++) begin : g_store
    bts_ram #(
      .WIDTH(bts_pkg::TEXEL_W),
      .DEPTH(bts_pkg::STORE_TEXELS)
    ) u_ram (
      .clk  (clk),
      .we   (ram_we),
      .waddr(d_index[bts_pkg::ADDR_W-1:0]),
      .wdata(d_rgba),
      .re   (adv),
      .raddr(raddr[i]),
      .rdata(rdata[i])
    );
  end

  // Stage E: texel quad in the memory output registers.
  logic        e_valid;
  logic [15:0] e_tx, e_ty;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else if (adv) begin
      e_valid <= d_valid && (d_op == bts_pkg::OP_SAMPLE);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_tx <= d_px[15:0];
      e_ty <= d_py[15:0];
    end
  end

  // Stage F: channel numerators and bilinear weights.
  function automatic logic [9:0] chan(input logic [31:0] t, input logic [2:0] sel);
    logic [9:0] n;
    unique case (sel)
      bts_pkg::CH_GREEN: n = {2'b00, t[15:8]};
      bts_pkg::CH_BLUE:  n = {2'b00, t[23:16]};
      bts_pkg::CH_ALPHA: n = {2'b00, t[31:24]};
      bts_pkg::CH_MEAN:  n = 10'(t[7:0]) + 10'(t[15:8]) + 10'(t[23:16]);
      default:           n = {2'b00, t[7:0]};
    endcase
    return n;
  endfunction

  logic        f_valid, f_mean;
  logic [9:0]  f_n [bts_pkg::QUAD];
  logic [32:0] f_w [bts_pkg::QUAD];
  logic [16:0] ix, iy;

  assign ix = 17'd65536 - {1'b0, e_tx};
  assign iy = 17'd65536 - {1'b0, e_ty};

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (adv) begin
      f_valid <= e_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f_mean <= (channel_select == bts_pkg::CH_MEAN);
      for (int i = 0; i < bts_pkg::QUAD; i++) begin
        f_n[i] <= chan(rdata[i], channel_select);
      end
      f_w[0] <= {16'd0, ix} * {16'd0, iy};
      f_w[1] <= {17'd0, e_tx} * {16'd0, iy};
      f_w[2] <= {16'd0, ix} * {17'd0, e_ty};
      f_w[3] <= {17'd0, e_tx} * {17'd0, e_ty};
    end
  end

  // Stage G: weighted numerators.
  logic        g_valid, g_mean;
  logic [42:0] g_p [bts_pkg::QUAD];

  always_ff @(posedge clk) begin
    if (rst) begin
      g_valid <= 1'b0;
    end else if (adv) begin
      g_valid <= f_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      g_mean <= f_mean;
      for (int i = 0; i < bts_pkg::QUAD; i++) begin
        g_p[i] <= f_n[i] * f_w[i];
      end
    end
  end

  // Stage H: accumulation.
  logic        h_valid, h_mean;
  logic [43:0] h_acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      h_valid <= 1'b0;
    end else if (adv) begin
      h_valid <= g_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      h_mean <= g_mean;
      h_acc  <= 44'(g_p[0]) + 44'(g_p[1]) + 44'(g_p[2]) + 44'(g_p[3]);
    end
  end

  // Stage I: scale to 16 bits with rounding bias, before the divide by the denominator.
  logic        i_valid, i_mean;
  logic [25:0] i_num;
  logic [9:0]  den;
  logic [60:0] scaled;

  assign den    = h_mean ? 10'd765 : 10'd255;
  assign scaled = ({17'd0, h_acc} << 16) - {17'd0, h_acc} + ({51'd0, den} << 31);

  always_ff @(posedge clk) begin
    if (rst) begin
      i_valid <= 1'b0;
    end else if (adv) begin
      i_valid <= h_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      i_mean <= h_mean;
      i_num  <= scaled[57:32];
    end
  end

  // Stage J: reciprocal multiply.
  logic        j_valid, j_mean;
  logic [52:0] j_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      j_valid <= 1'b0;
    end else if (adv) begin
      j_valid <= i_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      j_mean <= i_mean;
      j_prod <= i_num * (i_mean ? bts_pkg::RECIP_765 : bts_pkg::RECIP_255);
    end
  end

  // Output register with saturation, backed by one skid register.
  logic [52:0] quot;
  logic [15:0] sat_value;
  logic [15:0] skid_value;

  assign quot      = j_mean ? (j_prod >> bts_pkg::SHIFT_765) : (j_prod >> bts_pkg::SHIFT_255);
  assign sat_value = (quot > 53'd65535) ? 16'hFFFF : quot[15:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (!rsp_stall) begin
        skid_valid <= 1'b0;
      end
    end else if (rsp_valid && rsp_stall) begin
      skid_valid <= j_valid;
    end else begin
      rsp_valid <= j_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (!rsp_stall) begin
        sample_value <= skid_value;
      end
    end else if (rsp_valid && rsp_stall) begin
      skid_value <= sat_value;
    end else begin
      sample_value <= sat_value;
    end
  end

endmodule

// ===== src/bts_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module bts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for the bilinear texture sampler with a scoreboard predictor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  DRAIN_CYCLES = 16;
  localparam int  CYCLE_LIMIT  = 2000000;
  localparam int  ITEM_TARGET  = 1750;

  class sample_scoreboard;
    bit [31:0]         texels [bts_pkg::STORE_TEXELS];
    int unsigned       width_reg, height_reg;
    longint            scl_u, scl_v, off_u, off_v;
    bit                clamp;
    bit [2:0]          chan;
    bit [15:0]         expected [$];
    int                errors;

    function new();
      width_reg = 1;
      height_reg = 1;
      scl_u = 65536;
      scl_v = 65536;
      off_u = 0;
      off_v = 0;
      clamp = 0;
      chan = 0;
      errors = 0;
    endfunction

    function void write_reg(bts_pkg::cfg_reg_t idx, bit [31:0] v);
      case (idx)
        bts_pkg::REG_TEX_WIDTH:      width_reg = v[8:0];
        bts_pkg::REG_TEX_HEIGHT:     height_reg = v[8:0];
        bts_pkg::REG_SCALE_U:        scl_u = longint'($signed(v));
        bts_pkg::REG_SCALE_V:        scl_v = longint'($signed(v));
        bts_pkg::REG_OFFSET_U:       off_u = longint'($signed(v));
        bts_pkg::REG_OFFSET_V:       off_v = longint'($signed(v));
        bts_pkg::REG_CLAMP_MODE:     clamp = v[0];
        bts_pkg::REG_CHANNEL_SELECT: chan = v[2:0];
        default: ;
      endcase
    endfunction

    function longint unsigned eff_dim(int unsigned d);
      if (d == 0) return 1;
      if (d > bts_pkg::MAX_DIM) return bts_pkg::MAX_DIM;
      return d;
    endfunction

    function longint unsigned axis_pos(longint c, longint scale, longint offset,
                                       longint unsigned dim);
      longint p, s;
      longint unsigned f;
      p = c * scale;
      if (p >= 0) s = p / 65536;
      else s = -((-p + 65535) / 65536);
      s += offset;
      if (clamp) begin
        if (s < 0) s = 0;
        if (s > 65536) s = 65536;
        f = s;
      end else begin
        f = ((s % 65536) + 65536) % 65536;
      end
      return f * (dim > 1 ? dim - 1 : 1);
    endfunction

    function longint unsigned texel_channel(longint unsigned x, longint unsigned y,
                                            longint unsigned w, longint unsigned h);
      bit [31:0] t;
      if (x > w - 1) x = w - 1;
      if (y > h - 1) y = h - 1;
      t = texels[(y * w + x) % bts_pkg::STORE_TEXELS];
      case (chan)
        bts_pkg::CH_GREEN: return t[15:8];
        bts_pkg::CH_BLUE:  return t[23:16];
        bts_pkg::CH_ALPHA: return t[31:24];
        bts_pkg::CH_MEAN:  return t[7:0] + t[15:8] + t[23:16];
        default:           return t[7:0];
      endcase
    endfunction

    function void note_request(bts_pkg::op_t op, bit [15:0] idx, bit [31:0] rgba,
                               bit [31:0] u, bit [31:0] v);
      longint unsigned w, h, fx, fy, x0, y0, x1, y1, tx, ty, d, acc, r;
      if (op == bts_pkg::OP_WRITE) begin
        texels[idx] = rgba;
        return;
      end
      w = eff_dim(width_reg);
      h = eff_dim(height_reg);
      fx = axis_pos(longint'($signed(u)), scl_u, off_u, w);
      fy = axis_pos(longint'($signed(v)), scl_v, off_v, h);
      x0 = fx >> 16;
      y0 = fy >> 16;
      tx = fx & 16'hFFFF;
      ty = fy & 16'hFFFF;
      x1 = (x0 + 1 < w - 1) ? x0 + 1 : w - 1;
      y1 = (y0 + 1 < h - 1) ? y0 + 1 : h - 1;
      d = (chan == bts_pkg::CH_MEAN) ? 765 : 255;
      acc = texel_channel(x0, y0, w, h) * ((65536 - tx) * (65536 - ty))
          + texel_channel(x1, y0, w, h) * (tx * (65536 - ty))
          + texel_channel(x0, y1, w, h) * ((65536 - tx) * ty)
          + texel_channel(x1, y1, w, h) * (tx * ty);
      r = (acc * 65535 + d * (64'd1 << 31)) / (d * (64'd1 << 32));
      if (r > 65535) r = 65535;
      expected.push_back(r[15:0]);
    endfunction

    function void check_sample(bit [15:0] got);
      bit [15:0] e;
      if (expected.size() == 0) begin
        $display("%0t unexpected sample_value %0d", $time, got);
        errors++;
        return;
      end
      e = expected.pop_front();
      if (e !== got) begin
        $display("%0t sample_value expected %0d got %0d", $time, e, got);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        req_valid = 0;
  logic        req_stall;
  logic        operation = 0;
  logic [15:0] texel_index = 0;
  logic [31:0] texel_rgba = 0;
  logic [31:0] coord_u = 0;
  logic [31:0] coord_v = 0;
  logic        rsp_valid;
  logic        rsp_stall = 0;
  logic [15:0] sample_value;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = 0;
  logic [31:0] cfg_data = 0;

  sample_scoreboard sb = new();
  int          burst_left = 0;
  int          gap_max = 4;
  int          sent = 0;
  int          stall_left = 0;
  int          stall_mode = 0;
  longint      cycles = 0;

  bilinear_texture_sampler dut (.*);

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && req_valid && !req_stall)
      sb.note_request(bts_pkg::op_t'(operation), texel_index, texel_rgba, coord_u, coord_v);
    if (!rst && rsp_valid && !rsp_stall)
      sb.check_sample(sample_value);
  end

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 200);
    end
    stall_left--;
    case (stall_mode)
      0: rsp_stall <= 1'b0;
      1: rsp_stall <= ($urandom_range(0, 3) == 0);
      2: rsp_stall <= ($urandom_range(0, 1) == 1);
      default: rsp_stall <= ($urandom_range(0, 9) != 0);
    endcase
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_req(bts_pkg::op_t op, bit [15:0] idx, bit [31:0] rgba,
                          bit [31:0] u, bit [31:0] v);
    if (burst_left == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, gap_max)) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    req_valid <= 1'b1;
    operation <= op;
    texel_index <= idx;
    texel_rgba <= rgba;
    coord_u <= u;
    coord_v <= v;
    do @(posedge clk); while (req_stall);
    sent++;
  endtask

  task automatic write_texel(bit [15:0] idx, bit [31:0] rgba);
    send_req(bts_pkg::OP_WRITE, idx, rgba, $urandom, $urandom);
  endtask

  task automatic sample(bit [31:0] u, bit [31:0] v);
    send_req(bts_pkg::OP_SAMPLE, 16'($urandom), $urandom, u, v);
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (sb.expected.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(bts_pkg::cfg_reg_t idx, bit [31:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.write_reg(idx, v);
    @(posedge clk);
  endtask

  task automatic set_texture(bit [8:0] w, bit [8:0] h);
    write_cfg(bts_pkg::REG_TEX_WIDTH, {23'd0, w});
    write_cfg(bts_pkg::REG_TEX_HEIGHT, {23'd0, h});
  endtask

  task automatic fill_texture();
    longint unsigned n;
    n = sb.eff_dim(sb.width_reg) * sb.eff_dim(sb.height_reg);
    for (longint unsigned i = 0; i < n; i++) write_texel(16'(i), $urandom);
  endtask

  function automatic bit [31:0] pick_q();
    bit [31:0] q;
    case ($urandom_range(0, 6))
      0: q = 32'h0001_0000;
      1: q = $urandom;
      2: q = 32'h8000_0000;
      3: q = 32'h7FFF_FFFF;
      4: q = 32'h0;
      default: begin
        q = ($urandom_range(0, 4) << 16) | $urandom_range(0, 65535);
        if ($urandom_range(0, 1)) q = -q;
      end
    endcase
    return q;
  endfunction

  function automatic bit [8:0] pick_dim();
    case ($urandom_range(0, 9))
      0: return 9'd0;
      1: return 9'd256;
      2: return 9'($urandom_range(257, 511));
      default: return 9'($urandom_range(1, 12));
    endcase
  endfunction

  initial begin
    bit [8:0] w, h;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset configuration, extremes, every channel code and both modes.
    write_texel(16'h0, 32'hFF80_4010);
    sample(32'h0, 32'h0);
    sample(32'h7FFF_FFFF, 32'h8000_0000);
    drain();
    set_texture(9'd4, 9'd3);
    write_cfg(bts_pkg::REG_SCALE_U, 32'h0001_0000);
    write_cfg(bts_pkg::REG_SCALE_V, 32'h0001_0000);
    write_cfg(bts_pkg::REG_OFFSET_U, 32'h0);
    write_cfg(bts_pkg::REG_OFFSET_V, 32'h0);
    for (int i = 0; i < 12; i++) write_texel(16'(i), (i % 2) ? 32'hFFFF_FFFF : 32'h0);
    for (int c = 0; c < 8; c++) begin
      drain();
      write_cfg(bts_pkg::REG_CHANNEL_SELECT, c);
      write_cfg(bts_pkg::REG_CLAMP_MODE, c % 2);
      sample(32'h0000_8000, 32'h0001_0000);
      sample(32'hFFFF_FFFF, 32'h7FFF_FFFF);
    end
    drain();
    set_texture(9'd0, 9'd511);
    fill_texture();
    sample(32'h8000_0000, 32'h0000_C000);
    drain();
    set_texture(9'd511, 9'd0);
    fill_texture();
    sample(32'h0000_FFFF, 32'h0);

    while (sent < ITEM_TARGET + 25) begin
      drain();
      w = pick_dim();
      h = pick_dim();
      if (sb.eff_dim(w) * sb.eff_dim(h) > 600) begin
        if ($urandom_range(0, 1)) h = 9'($urandom_range(1, 2));
        else w = 9'($urandom_range(1, 2));
      end
      set_texture(w, h);
      write_cfg(bts_pkg::REG_SCALE_U, pick_q());
      write_cfg(bts_pkg::REG_SCALE_V, pick_q());
      write_cfg(bts_pkg::REG_OFFSET_U, pick_q());
      write_cfg(bts_pkg::REG_OFFSET_V, pick_q());
      write_cfg(bts_pkg::REG_CLAMP_MODE, $urandom_range(0, 1));
      write_cfg(bts_pkg::REG_CHANNEL_SELECT, $urandom_range(0, 7));
      gap_max = $urandom_range(0, 2) == 0 ? 1 : $urandom_range(2, 8);
      fill_texture();
      for (int i = 0; i < 120; i++) begin
        if ($urandom_range(0, 4) == 0) begin
          if ($urandom_range(0, 1))
            write_texel(16'($urandom_range(0, 32'(sb.eff_dim(sb.width_reg) *
                                                   sb.eff_dim(sb.height_reg) - 1))),
                        $urandom);
          else
            write_texel(16'($urandom), $urandom);
        end else if ($urandom_range(0, 1)) begin
          sample($urandom, $urandom);
        end else begin
          sample($urandom_range(0, 65536), $urandom_range(0, 65536));
        end
      end
    end

    drain();
    if (sb.errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end
endmodule

// ===== bilinear_texture_sampler.f =====
src/bts_pkg.sv
src/bts_ram.sv
src/bilinear_texture_sampler.sv
test/tb.sv
